// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the occupancy bitmap block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/oobu_pkg.sv
// Package with shared constants, types and a helper function of the occupancy bitmap block.
`timescale 1ns / 1ps
package oobu_pkg;

    localparam int LEVELS_DEF = 3;
    localparam int COORD_W    = 32;
    localparam int WIDE_W     = 34;
    localparam int CFG_IDX_W  = 2;
    localparam int LEAF_W     = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 2'd2;

    localparam logic [7:0] MASK_FULL = 8'hFF;

    typedef struct packed {
        logic clr;
        logic start;
        logic desc;
        logic asc;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
    } sts_t;

    function automatic int lvl_width(input int levels);
        return (levels > 1) ? $clog2(levels) : 1;
    endfunction

endpackage

// File: hw/rtl/octree_occupancy_bitmap_update.sv
// Top level of the octree occupancy bitmap update block.
//
// Channel   Direction  Handshake           Payload
// config    in         cfg_we              cfg_index, cfg_data
// input     in         in_valid/in_stall   chunk_x, chunk_y, chunk_z, is_loaded, is_empty
// result    out        out_valid/out_stall leaf_number, root masks, all_loaded, all_empty
//
// An item goes from acceptance to its result with one node read per level on the
// way down and one node write per level on the way up through the mask memory.
// After reset the block clears the mask memory, one node a cycle over all
// (8^LEVELS-1)/7 nodes, and accepts no item until that is done.
// A result waiting on out_stall holds the next item only in the S_FIN state.
`timescale 1ns / 1ps
module octree_occupancy_bitmap_update #(
    parameter int LEVELS = oobu_pkg::LEVELS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [oobu_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [oobu_pkg::COORD_W-1:0]          cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [oobu_pkg::COORD_W-1:0]   chunk_x,
    input  logic signed [oobu_pkg::COORD_W-1:0]   chunk_y,
    input  logic signed [oobu_pkg::COORD_W-1:0]   chunk_z,
    input  logic                                  is_loaded,
    input  logic                                  is_empty,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [oobu_pkg::LEAF_W-1:0]           leaf_number,
    output logic [7:0]                            root_loaded_mask,
    output logic [7:0]                            root_empty_mask,
    output logic                                  all_loaded,
    output logic                                  all_empty
);
    import oobu_pkg::*;

`include "assert_macros.svh"

    cmd_t                         cmd;
    sts_t                         sts;
    logic [lvl_width(LEVELS)-1:0] lvl;

    oobu_ctrl #(
        .LEVELS (LEVELS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd),
        .lvl       (lvl)
    );

    oobu_datapath #(
        .LEVELS (LEVELS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .chunk_x          (chunk_x),
        .chunk_y          (chunk_y),
        .chunk_z          (chunk_z),
        .is_loaded        (is_loaded),
        .is_empty         (is_empty),
        .cmd              (cmd),
        .lvl              (lvl),
        .sts              (sts),
        .leaf_number      (leaf_number),
        .root_loaded_mask (root_loaded_mask),
        .root_empty_mask  (root_empty_mask),
        .all_loaded       (all_loaded),
        .all_empty        (all_empty)
    );

    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    `ASSERT_SAME(a_load_when_free, clk, rst_n, cmd.load_out, !out_valid || !out_stall)
    `ASSERT_NEXT(a_ready_after_clear, clk, rst_n, cmd.clr && sts.clr_last, !in_stall)
    `ASSERT_NEXT(a_result_after_load, clk, rst_n, cmd.load_out, out_valid)

endmodule

// File: hw/rtl/oobu_ctrl.sv
// Controller state machine that sequences clearing, descent, ascent and result hand-off.
`timescale 1ns / 1ps
module oobu_ctrl #(
    parameter int LEVELS = oobu_pkg::LEVELS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    input  oobu_pkg::sts_t                            sts,
    output oobu_pkg::cmd_t                            cmd,
    output logic [oobu_pkg::lvl_width(LEVELS)-1:0]    lvl
);
    import oobu_pkg::*;

    localparam int LVW = lvl_width(LEVELS);
    localparam logic [LVW-1:0] LAST_LVL = LVW'(LEVELS - 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_DESC  = 6'b000100,
        S_WAIT  = 6'b001000,
        S_ASC   = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    state_t         state_reg, state_next;
    logic [LVW-1:0] lvl_reg, lvl_next;
    logic           out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        lvl_next   = lvl_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    lvl_next   = '0;
                    state_next = S_DESC;
                end
            end
            S_DESC:
            begin
                cmd.desc = 1'b1;
                if (lvl_reg == LAST_LVL)
                begin
                    state_next = S_WAIT;
                end
                else
                begin
                    lvl_next = lvl_reg + LVW'(1);
                end
            end
            S_WAIT:
            begin
                state_next = S_ASC;
            end
            S_ASC:
            begin
                cmd.asc = 1'b1;
                if (lvl_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    lvl_next = lvl_reg - LVW'(1);
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            lvl_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign lvl       = lvl_reg;

endmodule

// File: hw/rtl/oobu_datapath.sv
// Datapath with origin registers, center compares, path registers and the node mask memory.
`timescale 1ns / 1ps
module oobu_datapath #(
    parameter int LEVELS = oobu_pkg::LEVELS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_we,
    input  logic [oobu_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [oobu_pkg::COORD_W-1:0]              cfg_data,
    input  logic signed [oobu_pkg::COORD_W-1:0]       chunk_x,
    input  logic signed [oobu_pkg::COORD_W-1:0]       chunk_y,
    input  logic signed [oobu_pkg::COORD_W-1:0]       chunk_z,
    input  logic                                      is_loaded,
    input  logic                                      is_empty,
    input  oobu_pkg::cmd_t                            cmd,
    input  logic [oobu_pkg::lvl_width(LEVELS)-1:0]    lvl,
    output oobu_pkg::sts_t                            sts,
    output logic [oobu_pkg::LEAF_W-1:0]               leaf_number,
    output logic [7:0]                                root_loaded_mask,
    output logic [7:0]                                root_empty_mask,
    output logic                                      all_loaded,
    output logic                                      all_empty
);
    import oobu_pkg::*;

    localparam int LVW        = lvl_width(LEVELS);
    localparam int NODE_COUNT = ((1 << (3 * LEVELS)) - 1) / 7;
    localparam int NW         = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    logic [15:0] mem [NODE_COUNT];

    logic signed [COORD_W-1:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic signed [COORD_W-1:0] cx_reg, cy_reg, cz_reg;
    logic signed [WIDE_W-1:0]  lx_reg, ly_reg, lz_reg;
    logic [LEVELS-1:0]         half_reg;
    logic [NW-1:0]             node_reg;
    logic [LEAF_W-1:0]         leaf_reg;
    logic                      lfull_reg, efull_reg;
    logic [NW-1:0]             clr_cnt_reg;

    logic [NW-1:0]             path_node [LEVELS];
    logic [2:0]                path_child [LEVELS];
    logic [15:0]               path_mask [LEVELS];

    logic [15:0]               rd_data_reg;
    logic                      rd_val_reg;
    logic [LVW-1:0]            rd_lvl_reg;
    logic [15:0]               root_reg;

    logic [LEAF_W-1:0]         out_leaf_reg;
    logic [15:0]               out_root_reg;

    logic signed [WIDE_W-1:0]  half_w;
    logic signed [WIDE_W-1:0]  cx_w, cy_w, cz_w;
    logic signed [WIDE_W-1:0]  mx, my, mz;
    logic                      bx, by, bz;
    logic [2:0]                ci;
    logic [7:0]                bit8;
    logic [15:0]               pm;
    logic [7:0]                m_l, m_e;
    logic                      mem_we;
    logic [NW-1:0]             mem_waddr;
    logic [15:0]               mem_wdata;

    always_comb
    begin
        half_w = WIDE_W'($unsigned(half_reg));
        cx_w   = WIDE_W'(cx_reg);
        cy_w   = WIDE_W'(cy_reg);
        cz_w   = WIDE_W'(cz_reg);
        mx     = lx_reg + half_w;
        my     = ly_reg + half_w;
        mz     = lz_reg + half_w;
        bx     = (cx_w >= mx);
        by     = (cy_w >= my);
        bz     = (cz_w >= mz);
        ci     = {by, bz, bx};
    end

    always_comb
    begin
        pm   = path_mask[lvl];
        bit8 = 8'd1 << path_child[lvl];
        m_l  = lfull_reg ? (pm[7:0] | bit8) : (pm[7:0] & ~bit8);
        m_e  = efull_reg ? (pm[15:8] | bit8) : (pm[15:8] & ~bit8);
        mem_we    = cmd.clr | cmd.asc;
        mem_waddr = cmd.clr ? clr_cnt_reg : path_node[lvl];
        mem_wdata = cmd.clr ? 16'd0 : {m_e, m_l};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            clr_cnt_reg  <= '0;
            rd_val_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ORIGIN_X: origin_x_reg <= cfg_data;
                    CFG_ORIGIN_Y: origin_y_reg <= cfg_data;
                    CFG_ORIGIN_Z: origin_z_reg <= cfg_data;
                    default:      ;
                endcase
            end
            if (cmd.clr)
            begin
                clr_cnt_reg <= clr_cnt_reg + NW'(1);
            end
            rd_val_reg <= cmd.desc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            cx_reg    <= chunk_x;
            cy_reg    <= chunk_y;
            cz_reg    <= chunk_z;
            lx_reg    <= WIDE_W'(origin_x_reg);
            ly_reg    <= WIDE_W'(origin_y_reg);
            lz_reg    <= WIDE_W'(origin_z_reg);
            half_reg  <= LEVELS'(1) << (LEVELS - 1);
            node_reg  <= '0;
            leaf_reg  <= '0;
            lfull_reg <= is_loaded;
            efull_reg <= is_empty;
        end
        else if (cmd.desc)
        begin
            if (bx)
            begin
                lx_reg <= mx;
            end
            if (by)
            begin
                ly_reg <= my;
            end
            if (bz)
            begin
                lz_reg <= mz;
            end
            half_reg         <= half_reg >> 1;
            node_reg         <= NW'({node_reg, ci} + (NW + 3)'(1));
            leaf_reg         <= {leaf_reg[LEAF_W-4:0], ci};
            path_node[lvl]   <= node_reg;
            path_child[lvl]  <= ci;
        end
        else if (cmd.asc)
        begin
            lfull_reg <= (m_l == MASK_FULL);
            efull_reg <= (m_e == MASK_FULL);
            if (lvl == '0)
            begin
                root_reg <= {m_e, m_l};
            end
        end

        rd_lvl_reg <= lvl;
        if (rd_val_reg)
        begin
            path_mask[rd_lvl_reg] <= rd_data_reg;
        end

        if (cmd.load_out)
        begin
            out_leaf_reg <= leaf_reg;
            out_root_reg <= root_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.desc)
        begin
            rd_data_reg <= mem[node_reg];
        end
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    assign sts.clr_last      = (clr_cnt_reg == NW'(NODE_COUNT - 1));
    assign leaf_number       = out_leaf_reg;
    assign root_loaded_mask  = out_root_reg[7:0];
    assign root_empty_mask   = out_root_reg[15:8];
    assign all_loaded        = (out_root_reg[7:0] == MASK_FULL);
    assign all_empty         = (out_root_reg[15:8] == MASK_FULL);

endmodule
